// File: rtl/core/sro_pkg.sv
// ----------------------------------------------------------------------------
// Strided range overlap package
// Sequencer states for the overlap core and the width shared with its divider.
// ----------------------------------------------------------------------------
package sro_pkg;

    localparam int unsigned XW = 72;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EUC_DIV,
        ST_EUC_WAIT,
        ST_EUC_MUL,
        ST_EUC_UPD,
        ST_DELTA_DIV,
        ST_DELTA_WAIT,
        ST_MB_DIV,
        ST_MB_WAIT,
        ST_SM_DIV,
        ST_SM_WAIT,
        ST_XS_DIV,
        ST_XS_WAIT,
        ST_I0_MUL,
        ST_I0_DIV,
        ST_I0_WAIT,
        ST_J0_MUL,
        ST_J0_DIV,
        ST_J0_WAIT,
        ST_T_DIV,
        ST_T_WAIT,
        ST_HI_DIV,
        ST_HI_WAIT,
        ST_V1_DIV,
        ST_V1_WAIT,
        ST_V2_DIV,
        ST_V2_WAIT,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/sro_div.sv
// ----------------------------------------------------------------------------
// Strided range overlap divider
// Signed restoring divider, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module sro_div
    import sro_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [XW-1:0] dividend,
    input  logic signed [XW-1:0] divisor,
    output logic                 busy,
    output logic signed [XW-1:0] quotient,
    output logic signed [XW-1:0] remainder
);

    localparam int unsigned CW = $clog2(XW + 1);

    logic [XW-1:0] num_reg, num_next;
    logic [XW-1:0] den_reg, den_next;
    logic [XW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          qneg_reg, qneg_next;
    logic          rneg_reg, rneg_next;
    logic          busy_reg, busy_next;
    logic [XW:0]   trial;
    logic [XW-1:0] shifted;

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[XW-2:0], num_reg[XW-1]};
        trial     = {1'b0, shifted} - {1'b0, den_reg};
        if (start) begin
            num_next  = dividend[XW-1] ? XW'(-dividend) : dividend;
            den_next  = divisor[XW-1] ? XW'(-divisor) : divisor;
            rem_next  = '0;
            cnt_next  = CW'(XW);
            qneg_next = dividend[XW-1] ^ divisor[XW-1];
            rneg_next = dividend[XW-1];
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[XW]) begin
                rem_next = trial[XW-1:0];
                num_next = {num_reg[XW-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                num_next = {num_reg[XW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign busy      = busy_reg;
    assign quotient  = qneg_reg ? -$signed(num_reg) : $signed(num_reg);
    assign remainder = rneg_reg ? -$signed(rem_reg) : $signed(rem_reg);

endmodule

// File: rtl/core/strided_range_overlap_exact_core.sv
// ----------------------------------------------------------------------------
// Strided range overlap core
// Tells whether two strided address ranges share an element address.
// ----------------------------------------------------------------------------
// The input channel (s_valid/s_ready) carries one word holding both ranges as
// offset, stride and count. The result channel (m_valid/m_ready) returns one
// word with the overlaps flag for every input word, in order.
// One word is worked at a time. A shared 72-bit restoring divider and one
// 33-bit multiplier do the divisions and products under a small sequencer.
// Trivial cases (empty range, equal points) finish without a division;
// single-point cases take one division; the general case runs the extended
// Euclid loop, one division per step, plus up to ten further divisions.
// s_ready is high only while the block is idle.
// A finished result is held in the output register until m_ready takes it; a
// stalled receiver holds the block and s_ready stays low.
// Reset clears the sequencer and the output valid; no word is in flight.
// ----------------------------------------------------------------------------
module strided_range_overlap_exact_core
    import sro_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_first_offset,
    input  logic [31:0] s_first_stride,
    input  logic [30:0] s_first_count,
    input  logic [31:0] s_second_offset,
    input  logic [31:0] s_second_stride,
    input  logic [30:0] s_second_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_overlaps
);

    localparam int unsigned W = (WORD_BITS > 32) ? 32 : WORD_BITS;

    state_t state_reg, state_next;

    logic signed [XW-1:0] oa_reg, sa_reg, na_reg, ob_reg, sb_reg, nb_reg;
    logic signed [XW-1:0] r0_reg, r1_reg, s0_reg, s1_reg, q_reg, p_reg;
    logic signed [XW-1:0] m_reg, sm_reg, i0_reg, j0_reg, t_reg, lo_reg, hi_reg;
    logic signed [XW-1:0] dlt_reg, g_reg;
    logic signed [XW-1:0] r0_next, r1_next, s0_next, s1_next, q_next, p_next;
    logic signed [XW-1:0] m_next, sm_next, i0_next, j0_next, t_next;
    logic signed [XW-1:0] lo_next, hi_next, dlt_next, g_next;
    logic                 res_reg, res_next;
    logic                 mval_reg, mval_next;

    logic                 div_start;
    logic signed [XW-1:0] div_a, div_b, div_q, div_r;
    logic                 div_busy;
    logic signed [32:0]   mul_a, mul_b;
    logic signed [65:0]   mul_p;
    logic signed [XW-1:0] mul_y;

    logic signed [XW-1:0] in_oa, in_sa, in_ob, in_sb;
    logic signed [XW-1:0] fq, cq, pm;

    sro_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign mul_p = mul_a * mul_b;
    assign mul_y = XW'(mul_p);

    assign in_oa = XW'($signed(s_first_offset[W-1:0]));
    assign in_sa = XW'($signed(s_first_stride[W-1:0]));
    assign in_ob = XW'($signed(s_second_offset[W-1:0]));
    assign in_sb = XW'($signed(s_second_stride[W-1:0]));

    always_comb begin
        fq = div_q;
        if (div_r != 0 && (div_a[XW-1] != div_b[XW-1])) begin
            fq = div_q - 1;
        end
        cq = div_q;
        if (div_r != 0 && (div_a[XW-1] == div_b[XW-1])) begin
            cq = div_q + 1;
        end
        pm = div_r[XW-1] ? div_r + div_b : div_r;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = mval_reg;
    assign m_overlaps = res_reg;

    always_comb begin
        state_next = state_reg;
        r0_next = r0_reg; r1_next = r1_reg; s0_next = s0_reg; s1_next = s1_reg;
        q_next = q_reg; p_next = p_reg; m_next = m_reg; sm_next = sm_reg;
        i0_next = i0_reg; j0_next = j0_reg; t_next = t_reg;
        lo_next = lo_reg; hi_next = hi_reg; dlt_next = dlt_reg; g_next = g_reg;
        res_next  = res_reg;
        mval_next = mval_reg;
        div_start = 1'b0;
        div_a = '0;
        div_b = 1;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                r0_next = sa_reg[XW-1] ? -sa_reg : sa_reg;
                r1_next = sb_reg[XW-1] ? -sb_reg : sb_reg;
                s0_next = 1;
                s1_next = 0;
                dlt_next = ob_reg - oa_reg;
                if (na_reg == 0 || nb_reg == 0) begin
                    res_next = 1'b0;
                    state_next = ST_DONE;
                end else if (sa_reg == 0 && sb_reg == 0) begin
                    res_next = (oa_reg == ob_reg);
                    state_next = ST_DONE;
                end else if (sa_reg == 0 || sb_reg == 0) begin
                    state_next = ST_T_DIV;
                end else begin
                    state_next = ST_EUC_DIV;
                end
            end
            ST_EUC_DIV: begin
                if (r1_reg == 0) begin
                    g_next = r0_reg;
                    state_next = ST_DELTA_DIV;
                end else begin
                    div_start = 1'b1;
                    state_next = ST_EUC_WAIT;
                end
                div_a = r0_reg;
                div_b = r1_reg;
            end
            ST_EUC_WAIT: begin
                div_a = r0_reg;
                div_b = r1_reg;
                if (!div_busy) begin
                    q_next = div_q;
                    p_next = div_r;
                    state_next = ST_EUC_MUL;
                end
            end
            ST_EUC_MUL: begin
                mul_a = q_reg[32:0];
                mul_b = s1_reg[32:0];
                q_next = mul_y;
                state_next = ST_EUC_UPD;
            end
            ST_EUC_UPD: begin
                r0_next = r1_reg;
                r1_next = p_reg;
                s0_next = s1_reg;
                s1_next = s0_reg - q_reg;
                state_next = ST_EUC_DIV;
            end
            ST_DELTA_DIV: begin
                div_a = dlt_reg;
                div_b = g_reg;
                div_start = 1'b1;
                state_next = ST_DELTA_WAIT;
            end
            ST_DELTA_WAIT: begin
                div_a = dlt_reg;
                div_b = g_reg;
                if (!div_busy) begin
                    if (div_r != 0) begin
                        res_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        q_next = div_q;
                        state_next = ST_MB_DIV;
                    end
                end
            end
            ST_MB_DIV, ST_MB_WAIT: begin
                div_a = sb_reg[XW-1] ? -sb_reg : sb_reg;
                div_b = g_reg;
                div_start = (state_reg == ST_MB_DIV);
                if (state_reg == ST_MB_DIV) begin
                    state_next = ST_MB_WAIT;
                end else if (!div_busy) begin
                    m_next = div_q;
                    state_next = ST_SM_DIV;
                end
            end
            ST_SM_DIV, ST_SM_WAIT: begin
                div_a = q_reg;
                div_b = m_reg;
                div_start = (state_reg == ST_SM_DIV);
                if (state_reg == ST_SM_DIV) begin
                    state_next = ST_SM_WAIT;
                end else if (!div_busy) begin
                    sm_next = pm;
                    state_next = ST_XS_DIV;
                end
            end
            ST_XS_DIV, ST_XS_WAIT: begin
                div_a = sa_reg[XW-1] ? -s0_reg : s0_reg;
                div_b = m_reg;
                div_start = (state_reg == ST_XS_DIV);
                if (state_reg == ST_XS_DIV) begin
                    state_next = ST_XS_WAIT;
                end else if (!div_busy) begin
                    p_next = pm;
                    state_next = ST_I0_MUL;
                end
            end
            ST_I0_MUL: begin
                mul_a = p_reg[32:0];
                mul_b = sm_reg[32:0];
                p_next = mul_y;
                state_next = ST_I0_DIV;
            end
            ST_I0_DIV, ST_I0_WAIT: begin
                div_a = p_reg;
                div_b = m_reg;
                div_start = (state_reg == ST_I0_DIV);
                if (state_reg == ST_I0_DIV) begin
                    state_next = ST_I0_WAIT;
                end else if (!div_busy) begin
                    i0_next = pm;
                    state_next = ST_J0_MUL;
                end
            end
            ST_J0_MUL: begin
                mul_a = i0_reg[32:0];
                mul_b = sa_reg[32:0];
                p_next = mul_y - dlt_reg;
                state_next = ST_J0_DIV;
            end
            ST_J0_DIV, ST_J0_WAIT: begin
                div_a = p_reg;
                div_b = sb_reg;
                div_start = (state_reg == ST_J0_DIV);
                if (state_reg == ST_J0_DIV) begin
                    state_next = ST_J0_WAIT;
                end else if (!div_busy) begin
                    j0_next = div_q;
                    state_next = ST_T_DIV;
                end
            end
            ST_T_DIV, ST_T_WAIT: begin
                // In point mode this division tests membership of the point.
                if (sa_reg == 0) begin
                    div_a = oa_reg - ob_reg;
                    div_b = sb_reg;
                end else if (sb_reg == 0) begin
                    div_a = ob_reg - oa_reg;
                    div_b = sa_reg;
                end else begin
                    div_a = sa_reg;
                    div_b = g_reg;
                end
                div_start = (state_reg == ST_T_DIV);
                if (state_reg == ST_T_DIV) begin
                    state_next = ST_T_WAIT;
                end else if (!div_busy) begin
                    if (sa_reg == 0 || sb_reg == 0) begin
                        res_next = (div_r == 0) && !div_q[XW-1] &&
                                   (div_q < ((sa_reg == 0) ? nb_reg : na_reg));
                        state_next = ST_DONE;
                    end else begin
                        t_next = sb_reg[XW-1] ? -div_q : div_q;
                        if (na_reg - 1 - i0_reg < 0) begin
                            res_next = 1'b0;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_HI_DIV;
                        end
                    end
                end
            end
            ST_HI_DIV, ST_HI_WAIT: begin
                div_a = na_reg - 1 - i0_reg;
                div_b = m_reg;
                div_start = (state_reg == ST_HI_DIV);
                if (state_reg == ST_HI_DIV) begin
                    state_next = ST_HI_WAIT;
                end else if (!div_busy) begin
                    hi_next = fq;
                    lo_next = 0;
                    state_next = ST_V1_DIV;
                end
            end
            ST_V1_DIV, ST_V1_WAIT: begin
                div_a = !t_reg[XW-1] ? -j0_reg : nb_reg - 1 - j0_reg;
                div_b = t_reg;
                div_start = (state_reg == ST_V1_DIV);
                if (state_reg == ST_V1_DIV) begin
                    state_next = ST_V1_WAIT;
                end else if (!div_busy) begin
                    if (cq > lo_reg) begin
                        lo_next = cq;
                    end
                    state_next = ST_V2_DIV;
                end
            end
            ST_V2_DIV, ST_V2_WAIT: begin
                div_a = !t_reg[XW-1] ? nb_reg - 1 - j0_reg : -j0_reg;
                div_b = t_reg;
                div_start = (state_reg == ST_V2_DIV);
                if (state_reg == ST_V2_DIV) begin
                    state_next = ST_V2_WAIT;
                end else if (!div_busy) begin
                    res_next = (lo_reg <= ((fq < hi_reg) ? fq : hi_reg));
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mval_reg) begin
                    mval_next = 1'b1;
                end else if (m_ready) begin
                    mval_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
        if (s_valid && s_ready) begin
            oa_reg <= in_oa;
            sa_reg <= in_sa;
            na_reg <= XW'(s_first_count[W-2:0]);
            ob_reg <= in_ob;
            sb_reg <= in_sb;
            nb_reg <= XW'(s_second_count[W-2:0]);
        end
        r0_reg <= r0_next; r1_reg <= r1_next; s0_reg <= s0_next; s1_reg <= s1_next;
        q_reg <= q_next; p_reg <= p_next; m_reg <= m_next; sm_reg <= sm_next;
        i0_reg <= i0_next; j0_reg <= j0_next; t_reg <= t_next;
        lo_reg <= lo_next; hi_reg <= hi_next; dlt_reg <= dlt_next; g_reg <= g_next;
        res_reg  <= res_next;
    end

endmodule
